// ===== sv/bitach_pkg.sv =====
// Shared types and constants of the beam interval tachometer.
// Used by the top level and by the bit-serial divider; no dependencies.
`default_nettype none

package bitach_pkg;

    // Ring of stored beam intervals
    localparam int RING_DEPTH = 8;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 2);

    // Field widths
    localparam int TIME_W  = 32;
    localparam int THR_W   = 16;
    localparam int BEAMS_W = 7;
    localparam int RPM_W   = 24;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Datapath widths: sum of the ring, product avg*beams, divider quotient
    localparam int SUM_W  = TIME_W + $clog2(RING_DEPTH);
    localparam int DEN_W  = TIME_W + BEAMS_W;
    localparam int QUO_W  = (SUM_W > RPM_W) ? SUM_W : RPM_W;
    localparam int STEP_W = $clog2(QUO_W + 1);

    // Reset values
    localparam logic [TIME_W-1:0]  LAST_BREAK_RST = 32'd4294927296;
    localparam logic [THR_W-1:0]   THRESHOLD_RST  = 16'd625;
    localparam logic [BEAMS_W-1:0] BEAMS_RST      = 7'd8;

    // 60 s * 1000 ms * 256 (Q16.8), left-aligned in the divider's dividend
    localparam logic [RPM_W-1:0] RPM_NUM = 24'd15360000;
    localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};
    localparam logic [QUO_W-1:0] RPM_NUM_ALIGNED =
        QUO_W'(RPM_NUM) << (QUO_W - RPM_W);

    // Divider step counts
    localparam logic [STEP_W-1:0] AVG_STEPS = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] RPM_STEPS = STEP_W'(RPM_W);

    // Input kinds
    localparam logic OP_BEAM = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_VALID  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NODATA = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAMS     = 2'd1;

    // Divider request
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

`default_nettype wire

// ===== sv/bitach_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the average and
// the rpm conversion. Depends on bitach_pkg.
`default_nettype none

module bitach_div
    import bitach_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    input  wire logic [QUO_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [QUO_W-1:0]      o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [QUO_W-1:0]  r_quot;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_div;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] diff;
    logic           ge;

    // One trial subtraction per cycle
    assign rem_sh = {r_rem, r_quot[QUO_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = ~diff[DEN_W];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quot <= {r_quot[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== sv/beam_interval_tachometer_top.sv =====
// Beam interval tachometer, top level: interval ring, sequencer, output stage.
// Depends on bitach_pkg and bitach_div.
`default_nettype none

// Rotor speed meter fed with millisecond timestamps. A beam event (tuser 0)
// stores the interval since the previous break; it gives no result. A read
// (tuser 1) sums the first n ring entries (n = min(count, 8)), takes 35
// steps of the bit-serial divider for the average, multiplies, and takes 24
// more divider steps for rpm = 15360000 / (avg * beams), unsigned Q16.8; a
// zero denominator gives status "saturated". Reads with fewer than two
// stored intervals finish early with status "no data". One item is in
// work at a time; the result sits in an output register, so the next item
// is taken while it waits, unless a second read completes before the first
// result has been transferred. Configuration writes are always accepted.

module beam_interval_tachometer_top
    import bitach_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [TIME_W-1:0]    i_s_tdata,   // [31:0] time_ms
    input  wire logic                 i_s_tuser,   // [0] opcode
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [RPM_W-1:0]          o_m_tdata,   // [23:0] rpm_q8
    output logic [STAT_W-1:0]         o_m_tuser,   // [1:0] speed_status
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [THR_W-1:0]     i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ELAP  = 4'd1;
    localparam logic [3:0] S_STORE = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_D1    = 4'd5;
    localparam logic [3:0] S_D1W   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_D2    = 4'd8;
    localparam logic [3:0] S_D2W   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]         r_state;
    logic [3:0]         n_state;

    logic [THR_W-1:0]   r_threshold;
    logic [BEAMS_W-1:0] r_beams;

    logic [TIME_W-1:0]  r_ring [RING_DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [SLOT_W-1:0]  r_slot;
    logic [TIME_W-1:0]  r_last;

    logic               r_op;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_elapsed;
    logic [CNT_W-1:0]   r_n;
    logic [SLOT_W-1:0]  r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic [DEN_W-1:0]   r_denom;
    logic [RPM_W-1:0]   r_rpm;
    logic [STAT_W-1:0]  r_stat;

    logic               r_mvalid;
    logic [RPM_W-1:0]   r_mdata;
    logic [STAT_W-1:0]  r_muser;

    logic               s_xfer;
    logic               m_xfer;
    logic               do_store;
    logic               out_load;
    logic [CNT_W-1:0]   n_take;

    t_div_req           div_req;
    logic [QUO_W-1:0]   div_dividend;
    logic [DEN_W-1:0]   div_divisor;
    logic               div_done;
    logic [QUO_W-1:0]   div_quot;

    assign s_xfer   = i_s_tvalid && o_s_tready;
    assign m_xfer   = r_mvalid && i_m_tready;
    assign out_load = (r_state == S_OUT) && (!r_mvalid || i_m_tready);
    assign n_take   = (r_count < CNT_W'(RING_DEPTH)) ? r_count : CNT_W'(RING_DEPTH);

    // Beam events always store; reads store only after a long idle time
    assign do_store = (r_state == S_STORE) &&
                      ((r_op == OP_BEAM) || (r_elapsed > TIME_W'(r_threshold)));

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_beams     <= BEAMS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_BEAMS:     r_beams     <= i_cfg_data[BEAMS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_xfer) n_state = S_ELAP;
            S_ELAP:  n_state = S_STORE;
            S_STORE: n_state = (r_op == OP_BEAM) ? S_IDLE : S_CHK;
            S_CHK:   n_state = (r_count < CNT_W'(2)) ? S_OUT : S_SUM;
            S_SUM:   if (r_idx == SLOT_W'(r_n - 1'b1)) n_state = S_D1;
            S_D1:    n_state = S_D1W;
            S_D1W:   if (div_done) n_state = S_MUL;
            S_MUL:   n_state = S_D2;
            S_D2:    n_state = (r_denom == '0) ? S_OUT : S_D2W;
            S_D2W:   if (div_done) n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    // Ring bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_slot  <= '0;
            r_last  <= LAST_BREAK_RST;
        end else if (do_store) begin
            r_slot <= (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
            if (r_count < CNT_W'(RING_DEPTH + 1)) begin
                r_count <= r_count + 1'b1;
            end
            if (r_op == OP_BEAM) begin
                r_last <= r_time;
            end
        end
    end

    // Ring entries below the count are always written before they are read
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_ring[r_slot] <= r_elapsed;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op   <= i_s_tuser;
                r_time <= i_s_tdata;
            end
            S_ELAP: r_elapsed <= r_time - r_last;
            S_CHK: begin
                r_n   <= n_take;
                r_idx <= '0;
                r_sum <= '0;
                r_rpm  <= '0;
                r_stat <= ST_NODATA;
            end
            S_SUM: begin
                r_sum <= r_sum + SUM_W'(r_ring[r_idx]);
                r_idx <= r_idx + 1'b1;
            end
            S_MUL: r_denom <= DEN_W'(div_quot[TIME_W-1:0]) * DEN_W'(r_beams);
            S_D2: begin
                r_rpm  <= RPM_MAX;
                r_stat <= ST_SAT;
            end
            S_D2W: begin
                if (div_done) begin
                    r_rpm  <= div_quot[RPM_W-1:0];
                    r_stat <= ST_VALID;
                end
            end
            default: ;
        endcase
    end

    // Divider requests: average first, then the rpm conversion
    always_comb begin
        div_req.start = (r_state == S_D1) || ((r_state == S_D2) && (r_denom != '0));
        div_req.steps = (r_state == S_D1) ? AVG_STEPS : RPM_STEPS;
        div_dividend  = (r_state == S_D1) ? QUO_W'(r_sum) : RPM_NUM_ALIGNED;
        div_divisor   = (r_state == S_D1) ? DEN_W'(r_n) : r_denom;
    end

    bitach_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (out_load) begin
            r_mvalid <= 1'b1;
        end else if (m_xfer) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mdata <= r_rpm;
            r_muser <= r_stat;
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

endmodule

`default_nettype wire

// ===== sv/bitach_chk.sv =====
// Port-level checks of the beam interval tachometer, bound to the top level.
// Depends on bitach_pkg.
`default_nettype none

module bitach_chk
    import bitach_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              i_s_tready,
    input wire logic              i_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [RPM_W-1:0]  i_m_tdata,
    input wire logic [STAT_W-1:0] i_m_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tuser))
        else $error("stalled result changed");

    // Every transfer on the input leaves the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input accepted on back-to-back cycles");

    // Status codes go with their speed values: at most RPM_NUM when valid, zero for no data, all ones when saturated
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser == ST_VALID && i_m_tdata <= RPM_NUM)
                    || (i_m_tuser == ST_NODATA && i_m_tdata == '0)
                    || (i_m_tuser == ST_SAT && i_m_tdata == RPM_MAX))
        else $error("speed and status disagree");

    // A full-scale valid speed (denominator one) is never flagged as saturated
    a_vmin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == ST_VALID && i_m_tdata == RPM_NUM
        |-> i_m_tuser != ST_SAT)
        else $error("full-scale speed flagged");

endmodule

bind beam_interval_tachometer_top bitach_chk u_bitach_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ===== sim/beam_interval_tachometer_checker.sv =====
// Scoreboard for the beam interval tachometer: watches the input, result and register channels.
// Keeps its own model of the interval ring and predicts every speed result.
// Depends on bitach_pkg.
`default_nettype none

module beam_interval_tachometer_checker
    import bitach_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input stream, watched
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [TIME_W-1:0]    i_s_tdata,   // [31:0] time_ms
    input  wire logic                 i_s_tuser,   // [0] opcode
    // result stream, watched
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic [RPM_W-1:0]     i_m_tdata,   // [23:0] rpm_q8
    input  wire logic [STAT_W-1:0]    i_m_tuser,   // [1:0] speed_status
    // register writes, watched
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [THR_W-1:0]     i_cfg_data,
    // scoreboard status
    output int                        o_pending,
    output int                        o_failures,
    output int                        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [RPM_W-1:0]  rpm;
        logic [STAT_W-1:0] status;
    } t_speed;

    // Model state
    logic [TIME_W-1:0]  intervals [RING_DEPTH];
    logic [CNT_W-1:0]   stored;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  last_break;
    logic [THR_W-1:0]   threshold;
    logic [BEAMS_W-1:0] beams;

    t_speed speed_q[$];
    int     failures = 0;
    int     checked  = 0;

    // Ring write; count saturates one above the depth
    function automatic void store_interval(input logic [TIME_W-1:0] value);
        intervals[slot] = value;
        slot = (slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
        if (stored < CNT_W'(RING_DEPTH + 1))
            stored = stored + 1'b1;
    endfunction

    // Speed read: optional idle interval, then average and convert
    function automatic t_speed read_speed(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] idle;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  avg;
        logic [DEN_W-1:0]  denom;
        logic [DEN_W-1:0]  quo;
        int unsigned       n;
        int unsigned       k;
        t_speed            r;
        idle = now - last_break;
        if (idle > TIME_W'(threshold))
            store_interval(idle);
        if (stored < CNT_W'(2)) begin
            r.rpm    = '0;
            r.status = ST_NODATA;
            return r;
        end
        n   = (stored < CNT_W'(RING_DEPTH)) ? stored : RING_DEPTH;
        sum = '0;
        for (k = 0; k < n; k++)
            sum = sum + SUM_W'(intervals[k]);
        avg   = sum / SUM_W'(n);
        denom = DEN_W'(avg) * DEN_W'(beams);
        // zero average or zero beam count saturates
        if (denom == '0) begin
            r.rpm    = RPM_MAX;
            r.status = ST_SAT;
            return r;
        end
        quo = DEN_W'(RPM_NUM) / denom;
        if (quo > DEN_W'(RPM_MAX)) begin
            r.rpm    = RPM_MAX;
            r.status = ST_SAT;
            return r;
        end
        r.rpm    = quo[RPM_W-1:0];
        r.status = ST_VALID;
        return r;
    endfunction

    // Track every transfer at the clock edge it happens on
    always @(posedge i_clk) begin
        t_speed got;
        t_speed want;
        if (!i_rst_n) begin
            foreach (intervals[k])
                intervals[k] = '0;
            stored     = '0;
            slot       = '0;
            last_break = LAST_BREAK_RST;
            threshold  = THRESHOLD_RST;
            beams      = BEAMS_RST;
            speed_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_THRESHOLD)
                    threshold = i_cfg_data;
                else if (i_cfg_index == CFG_BEAMS)
                    beams = i_cfg_data[BEAMS_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_BEAM) begin
                    store_interval(i_s_tdata - last_break);
                    last_break = i_s_tdata;
                end else begin
                    speed_q.push_back(read_speed(i_s_tdata));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.rpm    = i_m_tdata;
                got.status = i_m_tuser;
                checked++;
                if (speed_q.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result rpm_q8=%0d status=%0d",
                             $time, got.rpm, got.status);
                end else begin
                    want = speed_q.pop_front();
                    if (got.rpm !== want.rpm || got.status !== want.status) begin
                        failures++;
                        $display({"%0t: mismatch expected rpm_q8=%0d status=%0d,",
                                  " got rpm_q8=%0d status=%0d"},
                                 $time, want.rpm, want.status, got.rpm, got.status);
                    end
                end
            end
        end
        o_pending  <= speed_q.size();
        o_failures <= failures;
        o_checked  <= checked;
    end

endmodule

`default_nettype wire

// ===== sim/beam_interval_tachometer_top_tb.sv =====
// Stimulus and verdict for beam_interval_tachometer_top.
// Drives beam events, speed reads and register writes; the checker module scores results.
// Depends on bitach_pkg, beam_interval_tachometer_top and beam_interval_tachometer_checker.
`default_nettype none

module beam_interval_tachometer_top_tb
    import bitach_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES  = 400;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [TIME_W-1:0]    i_s_tdata   = '0;
    logic                 i_s_tuser   = OP_BEAM;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [RPM_W-1:0]     o_m_tdata;
    logic [STAT_W-1:0]    o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_THRESHOLD;
    logic [THR_W-1:0]     i_cfg_data  = '0;

    int o_pending;
    int o_failures;
    int o_checked;

    // Stimulus state
    logic [TIME_W-1:0] clock_ms  = '0;
    logic [TIME_W-1:0] thr_now   = TIME_W'(THRESHOLD_RST);
    bit                steady    = 1'b0;
    bit                hold_req  = 1'b0;
    int unsigned       items_sent = 0;
    int unsigned       reads_sent = 0;
    int unsigned       settings   = 1;
    int unsigned       cycles     = 0;

    beam_interval_tachometer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    beam_interval_tachometer_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (o_pending),
        .o_failures  (o_failures),
        .o_checked   (o_checked)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 150);
        return $urandom_range(1, 4);
    endfunction

    // Read time either inside or past the stopped threshold
    function automatic logic [TIME_W-1:0] read_offset();
        if ($urandom_range(0, 1) == 1)
            return $urandom_range(0, thr_now);
        return thr_now + $urandom_range(1, 5000);
    endfunction

    // One input transfer; valid stays high across back-to-back items
    task automatic send_item(input logic op, input logic [TIME_W-1:0] t);
        int unsigned gap;
        gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= t;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        if (op == OP_READ)
            reads_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every result, then let a beam event finish
    task automatic quiesce();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (o_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Run of breaks at a rough rate, then a few reads
    task automatic beam_burst();
        logic [TIME_W-1:0] span;
        case ($urandom_range(0, 3))
            0:       span = $urandom_range(0, 3);
            1:       span = $urandom_range(4, 60);
            2:       span = $urandom_range(60, 2000);
            default: span = $urandom_range(2000, 200000);
        endcase
        repeat ($urandom_range(1, 10)) begin
            clock_ms = clock_ms + span + $urandom_range(0, span / 8);
            send_item(OP_BEAM, clock_ms);
        end
        repeat ($urandom_range(1, 3))
            send_item(OP_READ, clock_ms + read_offset());
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned target;
        logic        op;
        target = items_sent + count;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                7: begin
                    // stray item anywhere in time
                    op       = 1'($urandom_range(0, 1));
                    clock_ms = $urandom();
                    send_item(op, clock_ms);
                end
                8: begin
                    // repeated timestamps push zero intervals into the ring
                    repeat ($urandom_range(1, 9))
                        send_item(OP_BEAM, clock_ms);
                    send_item(OP_READ, clock_ms + $urandom_range(0, 3));
                end
                9: begin
                    // run across the 32-bit wrap
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                    beam_burst();
                end
                default: beam_burst();
            endcase
            if ($urandom_range(0, 29) == 0)
                quiesce();
        end
    endtask

    task automatic run_phase(input logic [THR_W-1:0] thr, input logic [THR_W-1:0] beam_data,
                             input int unsigned count, input bit steady_mode, input bit hold);
        quiesce();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_BEAMS, beam_data);
        settings++;
        thr_now  = TIME_W'(thr);
        steady   = steady_mode;
        hold_req = hold;
        random_traffic(count);
    endtask

    // Result side: random stalls, a long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycles, o_pending);
        $display("beam_interval_tachometer_top regression: fail");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, first reads, wrap, zero average, threshold edge
        send_item(OP_READ, 32'd0);            // idle since reset stored, still too little data
        send_item(OP_BEAM, 32'd0);
        send_item(OP_READ, 32'd0);
        send_item(OP_BEAM, 32'hFFFF_FFFF);    // near-full-scale interval
        send_item(OP_READ, 32'hFFFF_FFFF);
        repeat (5) send_item(OP_BEAM, 32'hFFFF_FFFF);
        send_item(OP_BEAM, 32'd0);            // wraps to interval 1, ring wraps, count saturates
        repeat (2) send_item(OP_BEAM, 32'd0);
        send_item(OP_READ, 32'd0);            // average rounds to zero
        send_item(OP_READ, 32'd1000);         // idle interval inserted
        send_item(OP_BEAM, 32'd1);
        send_item(OP_READ, 32'd1);
        send_item(OP_READ, 32'd626);          // idle equals threshold: nothing stored
        send_item(OP_READ, 32'd627);          // one past threshold: stored

        run_phase(16'd1, 16'd1, 180, 1'b0, 1'b0);
        run_phase(16'd65535, 16'd64, 180, 1'b1, 1'b1);
        run_phase(16'd0, 16'd0, 150, 1'b0, 1'b0);
        quiesce();
        write_reg(CFG_SPARE_LO, THR_W'($urandom()));
        write_reg(CFG_SPARE_HI, THR_W'($urandom()));
        run_phase(16'hFFFF, 16'hFF7F, 150, 1'b0, 1'b0);   // upper data bits dropped: 127 beams
        run_phase(THR_W'($urandom_range(1, 65535)), THR_W'($urandom_range(1, 64)),
                  200, 1'b1, 1'b0);
        run_phase(THRESHOLD_RST, THR_W'(BEAMS_RST), 240, 1'b0, 1'b0);

        quiesce();
        $display("Sent %0d input transfers (%0d speed reads) under %0d register settings.",
                 items_sent, reads_sent, settings);
        $display("Compared %0d speed results with the prediction.", o_checked);
        if (o_failures == 0 && o_pending == 0)
            $display("beam_interval_tachometer_top regression: pass");
        else
            $display("beam_interval_tachometer_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== beam_interval_tachometer_top.f =====
sv/bitach_pkg.sv
sv/bitach_div.sv
sv/beam_interval_tachometer_top.sv
sv/bitach_chk.sv
sim/beam_interval_tachometer_checker.sv
sim/beam_interval_tachometer_top_tb.sv
